[rtl/core/dtw_pkg.sv]
// Shared types and constants of the double-tap window detector.
package dtw_pkg;

	localparam int unsigned CODE_W   = 8;
	localparam int unsigned CONF_W   = 17;
	localparam int unsigned RUN_W    = 6;
	localparam int unsigned REFR_W   = 8;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 17;

	localparam logic [CODE_W-1:0] CODE_SINGLE_TAP = 8'd0;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_RUN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLANK_RUN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REFRESH   = 2'd3;

	localparam logic [CONF_W-1:0] THRESHOLD_RESET = 17'd39322;
	localparam logic [RUN_W-1:0]  TAP_RUN_RESET   = 6'd1;
	localparam logic [RUN_W-1:0]  BLANK_RUN_RESET = 6'd1;
	localparam logic [REFR_W-1:0] REFRESH_RESET   = 8'd6;

	localparam logic [COUNT_W-1:0] DOUBLE_TAP_MIN = 5'd2;

	typedef struct packed {
		logic start;
	} scan_ctrl_t;

	typedef struct packed {
		logic               done;
		logic [COUNT_W-1:0] found;
	} scan_stat_t;

endpackage

[rtl/core/dtw_verdict_if.sv]
// Handshake channel that carries one classifier verdict.
interface dtw_verdict_if import dtw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] class_code;
	logic [CONF_W-1:0] confidence;

	modport source (output valid, output class_code, output confidence, input ready);
	modport sink (input valid, input class_code, input confidence, output ready);
endinterface

[rtl/core/dtw_result_if.sv]
// Handshake channel that carries one detection result.
interface dtw_result_if import dtw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] tap_total;
	logic               double_tap;

	modport source (output valid, output tap_total, output double_tap, input ready);
	modport sink (input valid, input tap_total, input double_tap, output ready);
endinterface

[rtl/core/double_tap_window_detector.sv]
// Top level of the double-tap window detector: configuration, window, sequencer and output.
// Each verdict transfer shifts one tap bit into the window. An item that is no tap, or that
// arrives while recognition is disabled, produces a zero count and goes from the idle state
// through the finish state back to idle. A scanned item also passes the scan state, where the
// scanner steps through one window entry per cycle. The result sits in an output
// register, so the next verdict is taken while the previous result waits for its transfer.
module double_tap_window_detector import dtw_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dtw_verdict_if.sink           verdict,
	dtw_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                  state_q;
	logic [CONF_W-1:0]       threshold_q;
	logic [RUN_W-1:0]        tap_len_q;
	logic [RUN_W-1:0]        blank_len_q;
	logic [REFR_W-1:0]       refresh_len_q;
	logic [WINDOW_DEPTH-1:0] window_q;
	logic                    enabled_q;
	logic [REFR_W-1:0]       refresh_cnt_q;
	logic [COUNT_W-1:0]      count_q;
	logic                    out_valid_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic                    out_double_q;

	logic       accept;
	logic       is_tap;
	logic       load_out;
	scan_ctrl_t scan_ctrl;
	scan_stat_t scan_stat;

	assign verdict.ready   = (state_q == ST_IDLE);
	assign accept          = verdict.valid && verdict.ready;
	assign is_tap          = (verdict.class_code == CODE_SINGLE_TAP)
	                         && (verdict.confidence >= threshold_q);
	assign scan_ctrl.start = accept && is_tap && enabled_q;
	assign load_out        = (state_q == ST_FINISH) && (!out_valid_q || result.ready);

	dtw_scan #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (scan_ctrl),
		.window    (window_q),
		.tap_len   (tap_len_q),
		.blank_len (blank_len_q),
		.stat      (scan_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= THRESHOLD_RESET;
			tap_len_q     <= TAP_RUN_RESET;
			blank_len_q   <= BLANK_RUN_RESET;
			refresh_len_q <= REFRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q   <= cfg_data;
				CFG_TAP_RUN:   tap_len_q     <= cfg_data[RUN_W-1:0];
				CFG_BLANK_RUN: blank_len_q   <= cfg_data[RUN_W-1:0];
				CFG_REFRESH:   refresh_len_q <= cfg_data[REFR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_q      <= '0;
			enabled_q     <= 1'b0;
			refresh_cnt_q <= '0;
			count_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						window_q <= {window_q[WINDOW_DEPTH-2:0], is_tap};
						count_q  <= '0;
						if (!enabled_q) begin
							if (refresh_cnt_q >= refresh_len_q) begin
								refresh_cnt_q <= '0;
								enabled_q     <= 1'b1;
							end else begin
								refresh_cnt_q <= refresh_cnt_q + REFR_W'(1);
							end
						end
						state_q <= scan_ctrl.start ? ST_SCAN : ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (scan_stat.done) begin
						count_q <= scan_stat.found;
						if (scan_stat.found >= DOUBLE_TAP_MIN) begin
							enabled_q <= 1'b0;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_count_q  <= count_q;
			out_double_q <= (count_q >= DOUBLE_TAP_MIN);
		end
	end

	assign result.valid      = out_valid_q;
	assign result.tap_total  = out_count_q;
	assign result.double_tap = out_double_q;

	assert property (@(posedge clk) disable iff (!arst_n) scan_stat.done |-> state_q == ST_SCAN)
		else $error("scan finished outside the scan state");
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after a verdict transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && count_q >= DOUBLE_TAP_MIN) |-> !enabled_q)
		else $error("recognition still enabled after a double tap");
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.double_tap == (result.tap_total >= DOUBLE_TAP_MIN))
		else $error("double tap flag disagrees with the tap total");

endmodule

[rtl/core/dtw_scan.sv]
// Window scanner that walks the tap window one entry per cycle and counts separated taps.
module dtw_scan import dtw_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scan_ctrl_t              ctrl,
	input  logic [WINDOW_DEPTH-1:0] window,
	input  logic [RUN_W-1:0]        tap_len,
	input  logic [RUN_W-1:0]        blank_len,
	output scan_stat_t              stat
);

	localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

	logic               busy_q;
	logic               done_q;
	logic [IDX_W-1:0]   idx_q;
	logic [RUN_W-1:0]   tap_run_q;
	logic [RUN_W-1:0]   blank_run_q;
	logic               want_tap_q;
	logic [COUNT_W-1:0] found_q;

	logic               bit_cur;
	logic [RUN_W-1:0]   tap_inc;
	logic [RUN_W-1:0]   blank_inc;
	logic [RUN_W-1:0]   tap_run_d;
	logic [RUN_W-1:0]   blank_run_d;
	logic               want_tap_d;
	logic [COUNT_W-1:0] found_d;

	assign bit_cur   = window[idx_q];
	assign tap_inc   = tap_run_q + RUN_W'(1);
	assign blank_inc = blank_run_q + RUN_W'(1);

	always_comb begin
		tap_run_d   = '0;
		blank_run_d = '0;
		want_tap_d  = want_tap_q;
		found_d     = found_q;
		priority if (bit_cur && want_tap_q) begin
			if (tap_inc >= tap_len) begin
				want_tap_d = 1'b0;
				found_d    = found_q + COUNT_W'(1);
			end else begin
				tap_run_d = tap_inc;
			end
		end else if (!bit_cur && !want_tap_q) begin
			if (blank_inc >= blank_len) begin
				want_tap_d = 1'b1;
			end else begin
				blank_run_d = blank_inc;
			end
		end else begin
			tap_run_d   = '0;
			blank_run_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			idx_q       <= '0;
			tap_run_q   <= '0;
			blank_run_q <= '0;
			want_tap_q  <= 1'b1;
			found_q     <= '0;
		end else if (ctrl.start) begin
			busy_q      <= 1'b1;
			done_q      <= 1'b0;
			idx_q       <= '0;
			tap_run_q   <= '0;
			blank_run_q <= '0;
			want_tap_q  <= 1'b1;
			found_q     <= '0;
		end else if (busy_q) begin
			tap_run_q   <= tap_run_d;
			blank_run_q <= blank_run_d;
			want_tap_q  <= want_tap_d;
			found_q     <= found_d;
			idx_q       <= idx_q + IDX_W'(1);
			if (idx_q == IDX_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.done  = done_q;
	assign stat.found = found_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("scan done while still busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("scan done held longer than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n) ctrl.start |=> busy_q && idx_q == '0)
		else $error("scan did not start at the first entry");

endmodule
